### rtl/core/hsbd_pkg.sv
package hsbd_pkg;

  localparam int CODE_BITS = 16;
  localparam int DATA_BITS = 11;
  localparam int ROW_COUNT = 4;
  localparam int MASK_COLS = 12;
  localparam int MASKS_W   = ROW_COUNT * MASK_COLS;

  // rows 1483, 1964, 1658, 861 packed low row first
  localparam logic [MASKS_W-1:0] MASKS_RESET = 48'd59195294139851;

  typedef logic [CODE_BITS-1:0] word_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [ROW_COUNT-1:0] syn_t;
  typedef logic [MASKS_W-1:0]   masks_t;

  typedef struct packed {
    data_t data_bits;
    logic  corrected;
    logic  uncorrectable;
  } result_t;

endpackage

### rtl/core/hsbd_collect.sv
module hsbd_collect #(
  parameter int GROUP_BITS = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_code_bit,
  output logic            cw_valid,
  input  logic            cw_ready,
  output hsbd_pkg::word_t cw_word
);

  localparam int PosW = $clog2(GROUP_BITS);
  localparam logic [PosW-1:0] PosLast = PosW'(GROUP_BITS - 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  hsbd_pkg::word_t word_r, word_nxt;
  hsbd_pkg::word_t word_cur;
  logic            is_last;
  logic            in_acc;

  assign is_last  = (pos_r == PosLast);
  // only the group's final bit needs room downstream
  assign in_ready = !is_last || cw_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    word_cur = word_r;
    if (int'(pos_r) < hsbd_pkg::CODE_BITS) begin
      word_cur[pos_r[3:0]] = in_code_bit;
    end
  end

  assign cw_valid = in_acc && is_last;
  assign cw_word  = word_cur;

  always_comb begin
    pos_nxt  = pos_r;
    word_nxt = word_r;
    if (in_acc) begin
      if (is_last) begin
        pos_nxt  = '0;
        word_nxt = '0;
      end else begin
        pos_nxt  = pos_r + 1'b1;
        word_nxt = word_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      word_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      word_r <= word_nxt;
    end
  end

endmodule

### rtl/core/hsbd_correct.sv
module hsbd_correct (
  input  logic              clk,
  input  logic              rst_n,
  input  hsbd_pkg::masks_t  masks,
  input  logic              cw_valid,
  output logic              cw_ready,
  input  hsbd_pkg::word_t   cw_word,
  output logic              res_valid,
  input  logic              res_ready,
  output hsbd_pkg::result_t res
);

  hsbd_pkg::syn_t    syn;
  hsbd_pkg::word_t   flip;
  hsbd_pkg::word_t   fixed;
  hsbd_pkg::syn_t    col_pat [hsbd_pkg::CODE_BITS];
  hsbd_pkg::result_t res_r, res_nxt;
  logic              vld_r, vld_nxt;
  logic              found;

  // syndrome: masked parity over columns 0-11 plus identity column
  always_comb begin
    for (int r = 0; r < hsbd_pkg::ROW_COUNT; r++) begin
      syn[r] = ^(masks[r*hsbd_pkg::MASK_COLS +: hsbd_pkg::MASK_COLS]
                 & cw_word[hsbd_pkg::MASK_COLS-1:0])
               ^ cw_word[hsbd_pkg::MASK_COLS + r];
    end
  end

  // column patterns of the check matrix
  always_comb begin
    for (int c = 0; c < hsbd_pkg::CODE_BITS; c++) begin
      col_pat[c] = '0;
      if (c < hsbd_pkg::MASK_COLS) begin
        for (int r = 0; r < hsbd_pkg::ROW_COUNT; r++) begin
          col_pat[c][r] = masks[r*hsbd_pkg::MASK_COLS + c];
        end
      end else begin
        col_pat[c][c - hsbd_pkg::MASK_COLS] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < hsbd_pkg::CODE_BITS; c++) begin
      flip[c] = (syn != '0) && (col_pat[c] == syn);
    end
  end

  assign found = |flip;
  assign fixed = cw_word ^ flip;

  assign cw_ready = !vld_r || res_ready;

  always_comb begin
    res_nxt = res_r;
    vld_nxt = vld_r;
    if (cw_ready) begin
      vld_nxt = cw_valid;
      if (cw_valid) begin
        res_nxt.data_bits     = fixed[hsbd_pkg::DATA_BITS-1:0];
        res_nxt.corrected     = found;
        res_nxt.uncorrectable = (syn != '0) && !found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = vld_r;
  assign res       = res_r;

endmodule

### rtl/core/hamming_sec_bit_stream_decoder.sv
// serial hamming (16,11) single-error-correcting decoder
//
// input channel: one code bit per item, least significant first. items are
// grouped in GROUP_BITS bits; positions 0-15 form the codeword and any later
// positions of the group are taken and dropped.
// result channel: one item per group with the 11 corrected data bits and the
// corrected / uncorrectable flags.
// config channel: the four 12-bit check-matrix row masks, always ready. write
// it only while no group is in progress and no result is pending.
//
// throughput: one code bit per cycle while in_ready is high, so one result per group.
// latency: the result is valid the cycle after the group's last bit is taken;
// syndrome, column match and flip are one level of xor/compare logic between
// the gathered word and the result register.
// stall: the result register holds its item until taken. bits keep flowing
// meanwhile; only the last bit of the next group waits (in_ready low) while
// the previous result is still unread.
// reset: position and partial word clear, no result pending, the row masks
// return to 1483, 1964, 1658, 861.
module hamming_sec_bit_stream_decoder #(
  parameter int GROUP_BITS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  // code bit items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_code_bit,
  // decoded items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_data_bits,
  output logic        out_corrected,
  output logic        out_uncorrectable,
  // row mask register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_parity_row_masks
);

  hsbd_pkg::masks_t  masks_r, masks_nxt;
  hsbd_pkg::word_t   cw_word;
  hsbd_pkg::result_t res;
  logic              cw_valid;
  logic              cw_ready;

  // config register, writable at any cycle
  assign cfg_ready = 1'b1;

  always_comb begin
    masks_nxt = masks_r;
    if (cfg_valid && cfg_ready) begin
      masks_nxt = cfg_parity_row_masks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= hsbd_pkg::MASKS_RESET;
    end else begin
      masks_r <= masks_nxt;
    end
  end

  // bit gathering and group framing
  hsbd_collect #(
    .GROUP_BITS (GROUP_BITS)
  ) u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_code_bit (in_code_bit),
    .cw_valid    (cw_valid),
    .cw_ready    (cw_ready),
    .cw_word     (cw_word)
  );

  // syndrome, correction and result register
  hsbd_correct u_correct (
    .clk       (clk),
    .rst_n     (rst_n),
    .masks     (masks_r),
    .cw_valid  (cw_valid),
    .cw_ready  (cw_ready),
    .cw_word   (cw_word),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_data_bits     = res.data_bits;
  assign out_corrected     = res.corrected;
  assign out_uncorrectable = res.uncorrectable;

endmodule
